// ----- hdl/lks_pkg.sv -----
// ----------------------------------------------------------------------------
// lks_pkg
// Shared constants, codes and controller/datapath types for the LRU key store.
// ----------------------------------------------------------------------------
package lks_pkg;

  localparam int unsigned KEY_W       = 64;
  localparam int unsigned CAP_W       = 5;
  localparam int unsigned ENTRIES_DEF = 16;

  localparam logic [CAP_W-1:0] CAP_RESET = 5'd16;

  localparam logic [1:0] CMD_LOOKUP = 2'd0;
  localparam logic [1:0] CMD_INSERT = 2'd1;
  localparam logic [1:0] CMD_DUMP   = 2'd2;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MATCH,
    ST_UPDATE,
    ST_RESP,
    ST_DUMP,
    ST_DRESP
  } state_e;

  typedef struct packed {
    logic load;
    logic match;
    logic update;
    logic dump_clr;
    logic dump_load;
    logic dump_step;
  } dp_cmd_t;

  typedef struct packed {
    logic last;
  } dp_sts_t;

endpackage

// ----- hdl/lru_key_store_top.sv -----
// ----------------------------------------------------------------------------
// lru_key_store_top
// Fully associative key store in recency order with lookup, insert and dump.
// ----------------------------------------------------------------------------
//  channel | direction | payload
//  in      | input     | cmd_i, lookup_key_i
//  out     | output    | hit_o, evicted_o, evicted_key_o, entry_key_o, last_o,
//          |           | store_empty_o
//  cfg     | input     | cfg_data_i (capacity in use)
//
//  Lookup and insert: accept, compare, update, then one result.
//  Dump: one result per rank, capacity results, read through the shared read port.
//  Reset: store empty, capacity 16.
//  A waiting result holds the block; no item is accepted until it is taken.
// ----------------------------------------------------------------------------
module lru_key_store_top
  import lks_pkg::*;
#(
  parameter int unsigned ENTRIES = ENTRIES_DEF
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    in_valid_i,
  output logic                    in_ready_o,
  input  logic        [1:0]       cmd_i,
  input  logic signed [KEY_W-1:0] lookup_key_i,
  output logic                    out_valid_o,
  input  logic                    out_ready_i,
  output logic                    hit_o,
  output logic                    evicted_o,
  output logic signed [KEY_W-1:0] evicted_key_o,
  output logic signed [KEY_W-1:0] entry_key_o,
  output logic                    last_o,
  output logic                    store_empty_o,
  input  logic                    cfg_valid_i,
  output logic                    cfg_ready_o,
  input  logic        [CAP_W-1:0] cfg_data_i
);

  dp_cmd_t dp_cmd;
  dp_sts_t dp_sts;

  lks_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .cmd_i       (cmd_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .dp_cmd_o    (dp_cmd),
    .dp_sts_i    (dp_sts)
  );

  lks_datapath #(
    .ENTRIES (ENTRIES)
  ) u_datapath (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cmd_i         (cmd_i),
    .lookup_key_i  (lookup_key_i),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_data_i    (cfg_data_i),
    .dp_cmd_i      (dp_cmd),
    .dp_sts_o      (dp_sts),
    .hit_o         (hit_o),
    .evicted_o     (evicted_o),
    .evicted_key_o (evicted_key_o),
    .entry_key_o   (entry_key_o),
    .last_o        (last_o),
    .store_empty_o (store_empty_o)
  );

endmodule

// ----- hdl/lks_ctrl.sv -----
// ----------------------------------------------------------------------------
// lks_ctrl
// Sequencer for lookup, insert and dump items; drives the datapath commands.
// ----------------------------------------------------------------------------
module lks_ctrl
  import lks_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  logic [1:0] cmd_i,
  output logic       out_valid_o,
  input  logic       out_ready_i,
  output dp_cmd_t    dp_cmd_o,
  input  dp_sts_t    dp_sts_i
);

  state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d     = state_q;
    in_ready_o  = 1'b0;
    out_valid_o = 1'b0;
    dp_cmd_o    = '0;
    case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          if (cmd_i == CMD_LOOKUP || cmd_i == CMD_INSERT) begin
            dp_cmd_o.load = 1'b1;
            state_d       = ST_MATCH;
          end else if (cmd_i == CMD_DUMP) begin
            dp_cmd_o.dump_clr = 1'b1;
            state_d           = ST_DUMP;
          end
        end
      end
      ST_MATCH: begin
        dp_cmd_o.match = 1'b1;
        state_d        = ST_UPDATE;
      end
      ST_UPDATE: begin
        dp_cmd_o.update = 1'b1;
        state_d         = ST_RESP;
      end
      ST_RESP: begin
        out_valid_o = 1'b1;
        if (out_ready_i) begin
          state_d = ST_IDLE;
        end
      end
      ST_DUMP: begin
        dp_cmd_o.dump_load = 1'b1;
        state_d            = ST_DRESP;
      end
      ST_DRESP: begin
        out_valid_o = 1'b1;
        if (out_ready_i) begin
          if (dp_sts_i.last) begin
            state_d = ST_IDLE;
          end else begin
            dp_cmd_o.dump_step = 1'b1;
            state_d            = ST_DUMP;
          end
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

endmodule

// ----- hdl/lks_datapath.sv -----
// ----------------------------------------------------------------------------
// lks_datapath
// Recency-ordered key registers, parallel match, promote/evict shift, dump
// read-out, capacity register and result registers.
// ----------------------------------------------------------------------------
module lks_datapath
  import lks_pkg::*;
#(
  parameter int unsigned ENTRIES = ENTRIES_DEF
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic        [1:0]       cmd_i,
  input  logic signed [KEY_W-1:0] lookup_key_i,
  input  logic                    cfg_valid_i,
  output logic                    cfg_ready_o,
  input  logic        [CAP_W-1:0] cfg_data_i,
  input  dp_cmd_t                 dp_cmd_i,
  output dp_sts_t                 dp_sts_o,
  output logic                    hit_o,
  output logic                    evicted_o,
  output logic signed [KEY_W-1:0] evicted_key_o,
  output logic signed [KEY_W-1:0] entry_key_o,
  output logic                    last_o,
  output logic                    store_empty_o
);

  localparam int unsigned OCC_W = $clog2(ENTRIES + 1);
  localparam int unsigned IW    = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam int unsigned CW    = (OCC_W > CAP_W) ? OCC_W : CAP_W;

  function automatic logic [OCC_W-1:0] eff_cap_f(input logic [CAP_W-1:0] cap);
    logic [CW-1:0] c;
    c = CW'(cap);
    if (c == '0) begin
      return OCC_W'(1);
    end else if (c > CW'(ENTRIES)) begin
      return OCC_W'(ENTRIES);
    end else begin
      return OCC_W'(c);
    end
  endfunction

  logic [KEY_W-1:0] keys_q [ENTRIES];
  logic [KEY_W-1:0] keys_d [ENTRIES];
  logic [KEY_W-1:0] key_q;
  logic [1:0]       cmd_q;
  logic [ENTRIES-1:0] match_q;
  logic [OCC_W-1:0] occ_q, occ_d;
  logic [CAP_W-1:0] cap_q;
  logic [IW-1:0]    dump_idx_q;

  logic [OCC_W-1:0] eff_cap;
  logic [OCC_W-1:0] cap_last;
  logic [IW-1:0]    rd_idx;
  logic [KEY_W-1:0] rd_key;
  logic             hit_any;
  logic [OCC_W-1:0] hit_pos;
  logic             shift_en;
  logic [OCC_W-1:0] shift_pos;
  logic             evict;
  logic             dump_last;

  assign cfg_ready_o = 1'b1;
  assign eff_cap     = eff_cap_f(cap_q);
  assign cap_last    = eff_cap - OCC_W'(1);
  assign rd_idx      = (dp_cmd_i.dump_load) ? dump_idx_q : cap_last[IW-1:0];
  assign rd_key      = keys_q[rd_idx];
  assign dump_last   = (OCC_W'(dump_idx_q) == cap_last);
  assign hit_any     = |match_q;
  assign dp_sts_o.last = last_o;

  always_comb begin
    hit_pos = '0;
    for (int i = ENTRIES - 1; i >= 0; i--) begin
      if (match_q[i]) begin
        hit_pos = OCC_W'(i);
      end
    end
  end

  always_comb begin
    shift_en  = 1'b0;
    shift_pos = '0;
    evict     = 1'b0;
    occ_d     = occ_q;
    if (cfg_valid_i) begin
      if (occ_q > eff_cap_f(cfg_data_i)) begin
        occ_d = eff_cap_f(cfg_data_i);
      end
    end else if (dp_cmd_i.update) begin
      if (hit_any) begin
        shift_en  = 1'b1;
        shift_pos = hit_pos;
      end else if (cmd_q == CMD_INSERT) begin
        shift_en = 1'b1;
        if (occ_q >= eff_cap) begin
          evict     = 1'b1;
          shift_pos = cap_last;
          occ_d     = eff_cap;
        end else begin
          shift_pos = occ_q;
          occ_d     = occ_q + OCC_W'(1);
        end
      end
    end
  end

  always_comb begin
    for (int i = 0; i < ENTRIES; i++) begin
      keys_d[i] = keys_q[i];
      if (shift_en) begin
        if (i == 0) begin
          keys_d[i] = key_q;
        end else if (OCC_W'(i) <= shift_pos) begin
          keys_d[i] = keys_q[(i > 0) ? i - 1 : 0];
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    for (int i = 0; i < ENTRIES; i++) begin
      keys_q[i] <= keys_d[i];
    end
    if (dp_cmd_i.load) begin
      key_q <= lookup_key_i;
      cmd_q <= cmd_i;
    end
    if (dp_cmd_i.match) begin
      for (int i = 0; i < ENTRIES; i++) begin
        match_q[i] <= (keys_q[i] == key_q) && (OCC_W'(i) < occ_q);
      end
    end
    if (dp_cmd_i.update) begin
      hit_o         <= hit_any;
      evicted_o     <= evict;
      evicted_key_o <= evict ? rd_key : '0;
      entry_key_o   <= '0;
      last_o        <= 1'b1;
      store_empty_o <= (occ_d == '0);
    end else if (dp_cmd_i.dump_load) begin
      hit_o         <= 1'b0;
      evicted_o     <= 1'b0;
      evicted_key_o <= '0;
      entry_key_o   <= (OCC_W'(dump_idx_q) < occ_q) ? rd_key : '0;
      last_o        <= dump_last;
      store_empty_o <= (occ_q == '0);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      occ_q      <= '0;
      cap_q      <= CAP_RESET;
      dump_idx_q <= '0;
    end else begin
      occ_q <= occ_d;
      if (cfg_valid_i) begin
        cap_q <= cfg_data_i;
      end
      if (dp_cmd_i.dump_clr) begin
        dump_idx_q <= '0;
      end else if (dp_cmd_i.dump_step) begin
        dump_idx_q <= dump_idx_q + IW'(1);
      end
    end
  end

`ifndef SYNTHESIS
  a_occ_within_cap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    occ_q <= eff_cap)
    else $error("occupancy above capacity");

  a_dump_idx_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    dp_cmd_i.dump_load |-> OCC_W'(dump_idx_q) < eff_cap)
    else $error("dump rank beyond capacity");

  a_update_occ_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    dp_cmd_i.update |=> (occ_q == $past(occ_q)) || (occ_q == $past(occ_q) + OCC_W'(1)))
    else $error("occupancy changed by more than one");

  a_evict_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    evict |-> (occ_q == eff_cap) && !hit_any)
    else $error("eviction while not full or on a hit");
`endif

endmodule
